[rtl/bptc_pkg.sv]
// Package for the barometric compensation block: payload words, coefficient set,
// register indexes and the word passed from the temperature path to the pressure path.
// Depends on nothing; used by every module in rtl.
package bptc_pkg;

  localparam int unsigned NumCoeffs = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned Latency   = 13;

  localparam logic [CfgIdxW-1:0] RegSensCoeff       = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOffsetCoeff     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSensTempCoeff   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOffsetTempCoeff = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRefTempCoeff    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTempSlopeCoeff  = 3'd5;

  localparam int unsigned OffW  = 42;
  localparam int unsigned SensW = 42;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pressure_pascal;
    logic signed [19:0] temperature_centi;
    logic               coefficients_invalid;
  } out_t;

  typedef struct packed {
    logic [15:0] sens_coeff;
    logic [15:0] offset_coeff;
    logic [15:0] sens_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] ref_temp_coeff;
    logic [15:0] temp_slope_coeff;
    logic        invalid;
  } coeff_t;

  typedef struct packed {
    logic                    valid;
    logic [23:0]             raw_pressure;
    logic signed [OffW-1:0]  off;
    logic signed [SensW-1:0] sens;
    logic signed [19:0]      temp;
    logic                    invalid;
  } comp_t;

endpackage

[rtl/baro_pressure_temp_compensation_unit.sv]
// Top level of the barometric pressure and temperature compensation block.
// Depends on bptc_pkg, bptc_coeff_regs, bptc_temp_path and bptc_press_path.
//
//   channel   handshake              payload
//   input     start & !busy          in_i  (bptc_pkg::in_t)
//   result    strobe_o, one cycle    res_o (bptc_pkg::out_t)
//   config    cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One word is accepted every cycle; busy is never raised.
// Each result is on res_o once its word has passed the eight stages of the temperature
// path and the five of the pressure path.
// Reset clears the coefficients and all valid bits; words in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module baro_pressure_temp_compensation_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  bptc_pkg::in_t                  in_i,
  output logic                           strobe_o,
  output bptc_pkg::out_t                 res_o,
  input  logic                           cfg_we_i,
  input  logic [bptc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bptc_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  bptc_pkg::coeff_t coef;
  bptc_pkg::comp_t  comp;
  logic             accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  bptc_coeff_regs u_coeff (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  bptc_temp_path u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .in_i    (in_i),
    .coef_i  (coef),
    .comp_o  (comp)
  );

  bptc_press_path u_press (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .comp_i   (comp),
    .strobe_o (strobe_o),
    .res_o    (res_o)
  );

  a_strobe_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(accept, bptc_pkg::Latency))
    else $error("result strobe without an accepted word");

endmodule

[rtl/bptc_coeff_regs.sv]
// Calibration coefficient registers with the write port and the invalid flag.
// Depends on bptc_pkg.
module bptc_coeff_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bptc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bptc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output bptc_pkg::coeff_t               coef_o
);

  logic [15:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic        bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bptc_pkg::RegSensCoeff:       c1_q <= cfg_wdata_i;
        bptc_pkg::RegOffsetCoeff:     c2_q <= cfg_wdata_i;
        bptc_pkg::RegSensTempCoeff:   c3_q <= cfg_wdata_i;
        bptc_pkg::RegOffsetTempCoeff: c4_q <= cfg_wdata_i;
        bptc_pkg::RegRefTempCoeff:    c5_q <= cfg_wdata_i;
        bptc_pkg::RegTempSlopeCoeff:  c6_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    bad = (c1_q == 16'h0000) || (c1_q == 16'hFFFF) ||
          (c2_q == 16'h0000) || (c2_q == 16'hFFFF) ||
          (c3_q == 16'h0000) || (c3_q == 16'hFFFF) ||
          (c4_q == 16'h0000) || (c4_q == 16'hFFFF) ||
          (c5_q == 16'h0000) || (c5_q == 16'hFFFF) ||
          (c6_q == 16'h0000) || (c6_q == 16'hFFFF);
  end

  assign coef_o.sens_coeff        = c1_q;
  assign coef_o.offset_coeff      = c2_q;
  assign coef_o.sens_temp_coeff   = c3_q;
  assign coef_o.offset_temp_coeff = c4_q;
  assign coef_o.ref_temp_coeff    = c5_q;
  assign coef_o.temp_slope_coeff  = c6_q;
  assign coef_o.invalid           = bad;

  a_write_c5: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == bptc_pkg::RegRefTempCoeff |=> c5_q == $past(cfg_wdata_i))
    else $error("reference temperature write lost");

endmodule

[rtl/bptc_temp_path.sv]
// Eight-stage pipeline: temperature difference, first-order temperature, offset and
// sensitivity, and the second-order correction. Depends on bptc_pkg.
module bptc_temp_path (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  bptc_pkg::in_t     in_i,
  input  bptc_pkg::coeff_t  coef_i,
  output bptc_pkg::comp_t   comp_o
);

  logic [7:0] vld_q;

  // Stage 1
  logic [23:0]        d1_1_q;
  logic signed [24:0] dt_q, dt_d;
  logic               inv_1_q;
  // Stage 2
  logic [23:0]        d1_2_q;
  logic signed [41:0] m6_q, m4_q, m3_q;
  logic signed [49:0] mdd_q;
  logic               inv_2_q;
  // Stage 3
  logic [23:0]        d1_3_q;
  logic signed [41:0] m6_b, m4_b, m3_b;
  logic signed [18:0] q6_q;
  logic signed [34:0] q4_q;
  logic signed [33:0] q3_q;
  logic [17:0]        t2_3_q;
  logic               inv_3_q;
  // Stage 4
  logic [23:0]        d1_4_q;
  logic signed [19:0] temp1_q;
  logic signed [36:0] off1_4_q;
  logic signed [35:0] sens1_4_q;
  logic signed [18:0] lo_q, vlo_q;
  logic               cold_4_q, vcold_4_q;
  logic [17:0]        t2_4_q;
  logic               inv_4_q;
  // Stage 5
  logic [23:0]        d1_5_q;
  logic signed [37:0] lo_sq, vlo_sq;
  logic [36:0]        lo2_q, vlo2_q;
  logic signed [20:0] temp2_d;
  logic signed [19:0] temp_5_q;
  logic signed [36:0] off1_5_q;
  logic signed [35:0] sens1_5_q;
  logic               cold_5_q, vcold_5_q;
  logic               inv_5_q;
  // Stage 6
  logic [23:0]        d1_6_q;
  logic [38:0]        a_q, b_q;
  logic [39:0]        c_q;
  logic signed [19:0] temp_6_q;
  logic signed [36:0] off1_6_q;
  logic signed [35:0] sens1_6_q;
  logic               cold_6_q;
  logic               inv_6_q;
  // Stage 7
  logic [23:0]        d1_7_q;
  logic [39:0]        off2_q, sens2_q;
  logic signed [19:0] temp_7_q;
  logic signed [36:0] off1_7_q;
  logic signed [35:0] sens1_7_q;
  logic               inv_7_q;
  // Stage 8
  logic [23:0]                       d1_8_q;
  logic signed [bptc_pkg::OffW-1:0]  off_q;
  logic signed [bptc_pkg::SensW-1:0] sens_q;
  logic signed [19:0]                temp_8_q;
  logic                              inv_8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  assign dt_d = $signed({1'b0, in_i.raw_temperature}) -
                $signed({1'b0, coef_i.ref_temp_coeff, 8'h00});

  always_comb begin
    m6_b   = m6_q + $signed({19'b0, {23{m6_q[41]}}});
    m4_b   = m4_q + $signed({35'b0, {7{m4_q[41]}}});
    m3_b   = m3_q + $signed({34'b0, {8{m3_q[41]}}});
    lo_sq  = lo_q * lo_q;
    vlo_sq = vlo_q * vlo_q;
    temp2_d = {temp1_q[19], temp1_q} -
              (cold_4_q ? $signed({3'b0, t2_4_q}) : 21'sd0);
  end

  always_ff @(posedge clk_i) begin
    d1_1_q  <= in_i.raw_pressure;
    dt_q    <= dt_d;
    inv_1_q <= coef_i.invalid;

    d1_2_q  <= d1_1_q;
    m6_q    <= dt_q * $signed({1'b0, coef_i.temp_slope_coeff});
    m4_q    <= dt_q * $signed({1'b0, coef_i.offset_temp_coeff});
    m3_q    <= dt_q * $signed({1'b0, coef_i.sens_temp_coeff});
    mdd_q   <= dt_q * dt_q;
    inv_2_q <= inv_1_q;

    d1_3_q  <= d1_2_q;
    q6_q    <= m6_b[41:23];
    q4_q    <= m4_b[41:7];
    q3_q    <= m3_b[41:8];
    t2_3_q  <= mdd_q[48:31];
    inv_3_q <= inv_2_q;

    d1_4_q    <= d1_3_q;
    temp1_q   <= {q6_q[18], q6_q} + 20'sd2000;
    off1_4_q  <= $signed({5'b0, coef_i.offset_coeff, 16'h0000}) + {{2{q4_q[34]}}, q4_q};
    sens1_4_q <= $signed({5'b0, coef_i.sens_coeff, 15'h0000}) + {{2{q3_q[33]}}, q3_q};
    lo_q      <= q6_q;
    vlo_q     <= q6_q + 19'sd3500;
    cold_4_q  <= q6_q[18];
    vcold_4_q <= q6_q < -19'sd3500;
    t2_4_q    <= t2_3_q;
    inv_4_q   <= inv_3_q;

    d1_5_q    <= d1_4_q;
    lo2_q     <= lo_sq[36:0];
    vlo2_q    <= vlo_sq[36:0];
    temp_5_q  <= temp2_d[19:0];
    off1_5_q  <= off1_4_q;
    sens1_5_q <= sens1_4_q;
    cold_5_q  <= cold_4_q;
    vcold_5_q <= vcold_4_q;
    inv_5_q   <= inv_4_q;

    d1_6_q    <= d1_5_q;
    a_q       <= cold_5_q ? ({lo2_q, 2'b00} + {2'b00, lo2_q}) : 39'd0;
    b_q       <= vcold_5_q ? ({vlo2_q, 2'b00} + {1'b0, vlo2_q, 1'b0} + {2'b00, vlo2_q})
                           : 39'd0;
    c_q       <= vcold_5_q ? ({vlo2_q, 3'b000} + {2'b00, vlo2_q, 1'b0} + {3'b000, vlo2_q})
                           : 40'd0;
    temp_6_q  <= temp_5_q;
    off1_6_q  <= off1_5_q;
    sens1_6_q <= sens1_5_q;
    cold_6_q  <= cold_5_q;
    inv_6_q   <= inv_5_q;

    d1_7_q    <= d1_6_q;
    off2_q    <= {2'b00, a_q[38:1]} + {1'b0, b_q};
    sens2_q   <= {3'b000, a_q[38:2]} + {1'b0, c_q[39:1]};
    temp_7_q  <= temp_6_q;
    off1_7_q  <= off1_6_q;
    sens1_7_q <= sens1_6_q;
    inv_7_q   <= inv_6_q;

    d1_8_q   <= d1_7_q;
    off_q    <= {{5{off1_7_q[36]}}, off1_7_q} - $signed({2'b00, off2_q});
    sens_q   <= {{6{sens1_7_q[35]}}, sens1_7_q} - $signed({2'b00, sens2_q});
    temp_8_q <= temp_7_q;
    inv_8_q  <= inv_7_q;
  end

  assign comp_o.valid        = vld_q[7];
  assign comp_o.raw_pressure = d1_8_q;
  assign comp_o.off          = off_q;
  assign comp_o.sens         = sens_q;
  assign comp_o.temp         = temp_8_q;
  assign comp_o.invalid      = inv_8_q;

  a_warm_no_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] && !cold_6_q |-> a_q == 39'd0 && b_q == 39'd0 && c_q == 40'd0)
    else $error("second-order terms active above twenty degrees");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] |-> temp_8_q >= -20'sd300000 && temp_8_q <= 20'sd300000)
    else $error("temperature outside its field range");

endmodule

[rtl/bptc_press_path.sv]
// Five-stage pipeline: split product of raw pressure and sensitivity, the two
// truncating scalings and the offset, ending in the result register. Depends on bptc_pkg.
module bptc_press_path (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bptc_pkg::comp_t  comp_i,
  output logic             strobe_o,
  output bptc_pkg::out_t   res_o
);

  logic [4:0] vld_q;

  logic [44:0]                      pl_q;
  logic signed [45:0]               ph_q;
  logic signed [bptc_pkg::OffW-1:0] off_1_q, off_2_q, off_3_q;
  logic signed [19:0]               temp_1_q, temp_2_q, temp_3_q, temp_4_q;
  logic                             inv_1_q, inv_2_q, inv_3_q, inv_4_q;
  logic signed [66:0]               prod_q, prod_b;
  logic signed [45:0]               x_q;
  logic signed [46:0]               y_q, y_b;
  bptc_pkg::out_t                   res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], comp_i.valid};
    end
  end

  always_comb begin
    prod_b = prod_q + $signed({46'b0, {21{prod_q[66]}}});
    y_b    = y_q + $signed({32'b0, {15{y_q[46]}}});
  end

  always_ff @(posedge clk_i) begin
    pl_q     <= comp_i.raw_pressure * comp_i.sens[20:0];
    ph_q     <= $signed({1'b0, comp_i.raw_pressure}) * $signed(comp_i.sens[41:21]);
    off_1_q  <= comp_i.off;
    temp_1_q <= comp_i.temp;
    inv_1_q  <= comp_i.invalid;

    prod_q   <= $signed({ph_q, 21'b0}) + $signed({22'b0, pl_q});
    off_2_q  <= off_1_q;
    temp_2_q <= temp_1_q;
    inv_2_q  <= inv_1_q;

    x_q      <= prod_b[66:21];
    off_3_q  <= off_2_q;
    temp_3_q <= temp_2_q;
    inv_3_q  <= inv_2_q;

    y_q      <= {x_q[45], x_q} - {{5{off_3_q[41]}}, off_3_q};
    temp_4_q <= temp_3_q;
    inv_4_q  <= inv_3_q;

    res_q.pressure_pascal      <= y_b[46:15];
    res_q.temperature_centi    <= temp_4_q;
    res_q.coefficients_invalid <= inv_4_q;
  end

  assign strobe_o = vld_q[4];
  assign res_o    = res_q;

endmodule

[sim/bptc_checker.sv]
// Checker for the barometric compensation block: follows the coefficient writes,
// predicts the compensated reading for every accepted word and compares it with the result.
// Depends on bptc_pkg.
module bptc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          word_start_i,
  input  logic                          busy_i,
  input  bptc_pkg::in_t                 word_i,
  input  logic                          res_strobe_i,
  input  bptc_pkg::out_t                res_i,
  input  logic                          cfg_we_i,
  input  logic [bptc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bptc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                            fail_cnt_o,
  output int                            pending_o,
  output int                            checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint T2Scale = 64'sd2147483648;

  logic [bptc_pkg::CfgDataW-1:0] coeff_q [bptc_pkg::NumCoeffs];
  bptc_pkg::out_t                readings_q [$];
  bptc_pkg::out_t                want;
  int                            fails = 0;
  int                            checked = 0;

  assign fail_cnt_o = fails;
  assign checked_o  = checked;

  function automatic bptc_pkg::out_t compensate_reading(input bptc_pkg::in_t w);
    longint         d1, d2, c1, c2, c3, c4, c5, c6;
    longint         dt, temp, off, sens, lo, vlo, t2, off2, sens2, p;
    logic           bad;
    bptc_pkg::out_t r;
    d1 = longint'(w.raw_pressure);
    d2 = longint'(w.raw_temperature);
    c1 = longint'(coeff_q[bptc_pkg::RegSensCoeff]);
    c2 = longint'(coeff_q[bptc_pkg::RegOffsetCoeff]);
    c3 = longint'(coeff_q[bptc_pkg::RegSensTempCoeff]);
    c4 = longint'(coeff_q[bptc_pkg::RegOffsetTempCoeff]);
    c5 = longint'(coeff_q[bptc_pkg::RegRefTempCoeff]);
    c6 = longint'(coeff_q[bptc_pkg::RegTempSlopeCoeff]);

    dt   = d2 - c5 * 256;
    temp = 2000 + (dt * c6) / 8388608;
    off  = c2 * 65536 + (c4 * dt) / 128;
    sens = c1 * 32768 + (c3 * dt) / 256;

    t2    = 0;
    off2  = 0;
    sens2 = 0;
    if (temp < 2000) begin
      lo    = temp - 2000;
      t2    = (dt * dt) / T2Scale;
      off2  = 5 * lo * lo / 2;
      sens2 = 5 * lo * lo / 4;
      if (temp < -1500) begin
        vlo   = temp + 1500;
        off2  = off2 + 7 * vlo * vlo;
        sens2 = sens2 + 11 * vlo * vlo / 2;
      end
    end
    temp = temp - t2;
    off  = off - off2;
    sens = sens - sens2;
    p    = ((d1 * sens) / 2097152 - off) / 32768;

    bad = 1'b0;
    foreach (coeff_q[i]) begin
      if (coeff_q[i] == '0 || coeff_q[i] == '1) bad = 1'b1;
    end

    r.pressure_pascal      = p[31:0];
    r.temperature_centi    = temp[19:0];
    r.coefficients_invalid = bad;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (coeff_q[i]) coeff_q[i] = '0;
      readings_q.delete();
      pending_o <= 0;
    end else begin
      if (res_strobe_i) begin
        if (readings_q.size() == 0) begin
          $error("result word with no reading pending");
          fails++;
        end else begin
          want = readings_q.pop_front();
          checked++;
          if (res_i.pressure_pascal !== want.pressure_pascal) begin
            $error("pressure_pascal expected %0d got %0d",
                   want.pressure_pascal, res_i.pressure_pascal);
            fails++;
          end
          if (res_i.temperature_centi !== want.temperature_centi) begin
            $error("temperature_centi expected %0d got %0d",
                   want.temperature_centi, res_i.temperature_centi);
            fails++;
          end
          if (res_i.coefficients_invalid !== want.coefficients_invalid) begin
            $error("coefficients_invalid expected %0b got %0b",
                   want.coefficients_invalid, res_i.coefficients_invalid);
            fails++;
          end
        end
      end
      if (word_start_i && !busy_i) readings_q.push_back(compensate_reading(word_i));
      if (cfg_we_i && cfg_idx_i < bptc_pkg::NumCoeffs) coeff_q[cfg_idx_i] = cfg_wdata_i;
      pending_o <= readings_q.size();
    end
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the barometric compensation block: drives conversion words and
// calibration writes, and reports the verdict from the checker's failure count.
// Depends on bptc_pkg, bptc_checker and baro_pressure_temp_compensation_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [bptc_pkg::CfgDataW-1:0] coeff_set_t [bptc_pkg::NumCoeffs];

  localparam logic [bptc_pkg::CfgIdxW-1:0] RegUnusedLo = 3'd6;
  localparam logic [bptc_pkg::CfgIdxW-1:0] RegUnusedHi = 3'd7;
  localparam coeff_set_t TypicalSet = '{16'd40127, 16'd36924, 16'd23317,
                                        16'd23282, 16'd33464, 16'd28312};

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  bptc_pkg::in_t                 in_i;
  logic                          strobe_o;
  bptc_pkg::out_t                res_o;
  logic                          cfg_we_i;
  logic [bptc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [bptc_pkg::CfgDataW-1:0] cfg_wdata_i;
  int                            fail_cnt;
  int                            pending;
  int                            checked;
  int                            sets_loaded = 0;
  int unsigned                   gap_pct [3] = '{19, 83, 0};

  baro_pressure_temp_compensation_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .strobe_o    (strobe_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bptc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_start_i (start),
    .busy_i       (busy),
    .word_i       (in_i),
    .res_strobe_i (strobe_o),
    .res_i        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_word(input logic [23:0] d1, input logic [23:0] d2,
                           input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= '{raw_pressure: d1, raw_temperature: d2};
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (bptc_pkg::Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_coeff(input logic [bptc_pkg::CfgIdxW-1:0] idx,
                             input logic [bptc_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_coeffs(input coeff_set_t set);
    for (int i = 0; i < bptc_pkg::NumCoeffs; i++)
      write_coeff(bptc_pkg::CfgIdxW'(i), set[i]);
    if ($urandom_range(3) == 0)
      write_coeff($urandom_range(1) ? RegUnusedHi : RegUnusedLo,
                  bptc_pkg::CfgDataW'($urandom));
    sets_loaded++;
  endtask

  function automatic coeff_set_t uniform_set(input logic [bptc_pkg::CfgDataW-1:0] v);
    coeff_set_t set;
    foreach (set[i]) set[i] = v;
    return set;
  endfunction

  function automatic coeff_set_t random_set(input bit near_typical);
    coeff_set_t set;
    foreach (set[i]) begin
      if (near_typical) begin
        set[i] = TypicalSet[i] + bptc_pkg::CfgDataW'($urandom_range(4000)) - 16'd2000;
      end else begin
        case ($urandom_range(19))
          0:       set[i] = '0;
          1:       set[i] = '1;
          2:       set[i] = 16'd1;
          3:       set[i] = 16'hFFFE;
          default: set[i] = bptc_pkg::CfgDataW'($urandom_range(16'hFFFF));
        endcase
      end
    end
    return set;
  endfunction

  function automatic logic [23:0] pick_raw_pressure();
    case ($urandom_range(9))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom_range(24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [23:0] pick_raw_temp(
    input logic [bptc_pkg::CfgDataW-1:0] ref_temp);
    longint v;
    v = longint'(ref_temp) * 256;
    case ($urandom_range(7))
      0, 1, 2, 3: v = v + longint'($urandom_range(8000000)) - 64'sd4000000;
      4, 5:       v = longint'($urandom_range(24'hFFFFFF));
      6:          v = $urandom_range(1) ? 64'sd0 : 64'sd16777215;
      default:    v = v;
    endcase
    if (v < 0) v = 0;
    if (v > 64'sd16777215) v = 64'sd16777215;
    return v[23:0];
  endfunction

  initial begin
    coeff_set_t cur;
    start       <= 1'b0;
    in_i        <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Coefficients straight out of reset are all zero and must be flagged.
    send_word(24'd9085466, 24'd8077636, 0);
    send_word(24'hFFFFFF, 24'd0, 0);
    wait_for_results();
    write_coeff(RegUnusedLo, 16'h1234);
    write_coeff(RegUnusedHi, 16'hFFFF);
    send_word(24'd0, 24'hFFFFFF, 0);
    wait_for_results();

    // Typical part: warm, reference point, mild cold and deep cold readings.
    load_coeffs(TypicalSet);
    send_word(24'd9085466, 24'd8077636, 0);
    send_word(24'd9085466, 24'd8566784, 0);
    send_word(24'd9085466, 24'd8066784, 0);
    send_word(24'd9085466, 24'd6566784, 0);
    send_word(24'd0, 24'd0, 0);
    send_word(24'hFFFFFF, 24'd0, 0);
    send_word(24'd0, 24'hFFFFFF, 0);
    send_word(24'hFFFFFF, 24'hFFFFFF, 0);
    wait_for_results();

    foreach (cur[i]) cur[i] = '0;
    for (int k = 0; k < 3; k++) begin
      case (k)
        0:       cur = uniform_set(16'hFFFF);
        1:       cur = uniform_set(16'd1);
        default: cur = uniform_set(16'hFFFE);
      endcase
      load_coeffs(cur);
      send_word(24'd0, 24'd0, 0);
      send_word(24'hFFFFFF, 24'hFFFFFF, 0);
      send_word(24'd9085466, 24'd8077636, 0);
      wait_for_results();
    end

    foreach (gap_pct[ph]) begin
      for (int s = 0; s < 6; s++) begin
        wait_for_results();
        cur = random_set(s % 2 == 0);
        load_coeffs(cur);
        repeat (103)
          send_word(pick_raw_pressure(), pick_raw_temp(cur[bptc_pkg::RegRefTempCoeff]),
                    gap_pct[ph]);
      end
    end
    wait_for_results();

    $display("%0d readings compared over %0d coefficient sets, gaps 19/83/0 percent",
             checked, sets_loaded);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bptc_pkg.sv
rtl/bptc_coeff_regs.sv
rtl/bptc_temp_path.sv
rtl/bptc_press_path.sv
rtl/baro_pressure_temp_compensation_unit.sv
sim/bptc_checker.sv
sim/tb_top.sv
